[src/cusum_change_probability_fusion_core_assert.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef CUSUM_CHANGE_PROBABILITY_FUSION_CORE_ASSERT_SVH
`define CUSUM_CHANGE_PROBABILITY_FUSION_CORE_ASSERT_SVH

// clocked check, quiet while reset is active
`define CCPF_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error(msg);

// clocked check that also holds during reset
`define CCPF_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[src/ccpf_pkg.sv]
// shared types, constants and the tail probability rom builder
// no dependencies
package ccpf_pkg;

    localparam int MAX_TIMES   = 64;
    localparam int TIME_W      = 6;
    localparam int SAMPLE_W    = 16;
    localparam int PROB_W      = 16;
    localparam int CDF_DEPTH   = 256;
    localparam int DIV_W       = 60;
    localparam int DSR_W       = 34;
    localparam int ROOT_W      = 30;

    localparam logic [1:0] REG_WARMUP    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_TIMES     = 2'd2;
    localparam logic [1:0] REG_BANDS     = 2'd3;

    localparam longint DEC = 64'sd1000000000;
    localparam longint DEC_SQ = DEC * DEC;
    localparam longint POLY_COEF [5] = '{64'sd319381530, -64'sd356563782, 64'sd1781477937,
                                        -64'sd1821255978, 64'sd1330274429};
    localparam longint EXP_COEF [6] = '{64'sd1000000000, 64'sd1000000000, 64'sd500000000,
                                       64'sd166666667, 64'sd41666667, 64'sd8333333};

    typedef struct packed {
        logic [5:0]  warmup_length;
        logic [15:0] tail_threshold;
        logic [6:0]  times_per_band;
        logic [4:0]  band_count;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_position;
        logic [PROB_W-1:0] fused_probability;
        logic              change_flag;
        logic              final_band;
    } result_t;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [DSR_W-1:0] rem0;
        logic [5:0]       nbits;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } div_res_t;

    typedef logic [PROB_W:0] rom_t [CDF_DEPTH];

    // long division of two positive values, shift and subtract
    function automatic longint pos_quot(longint a, longint b);
        longint q, r;
        q = 0;
        r = 0;
        for (int k = 62; k >= 0; k--)
        begin
            r = (r <<< 1) | ((a >>> k) & 64'sd1);
            if (r >= b)
            begin
                r = r - b;
                q = q | (64'sd1 <<< k);
            end
        end
        return q;
    endfunction

    function automatic logic [PROB_W:0] tail_entry(int i);
        longint zs, tt, h, poly, zk, y, e, phi, tail, q;
        zs = (longint'(i) * 8 * DEC) / CDF_DEPTH;
        tt = pos_quot(DEC_SQ, DEC + 64'sd231641900 * zs / DEC);
        h = POLY_COEF[4];
        for (int k = 3; k >= 0; k--) h = POLY_COEF[k] + tt * h / DEC;
        poly = tt * h / DEC;
        zk = zs / 1000;
        y = (zk * zk / 2000) / 256;
        e = EXP_COEF[5];
        for (int k = 4; k >= 0; k--) e = EXP_COEF[k] - y * e / DEC;
        if (e < 0) e = 0;
        for (int k = 0; k < 8; k++) e = e * e / DEC;
        phi = e * 64'sd398942280 / DEC;
        tail = 2 * phi * poly / DEC;
        if (tail < 0) tail = 0;
        q = (tail * 64'sd65536 + DEC / 2) / DEC;
        if (q > 64'sd65536) q = 64'sd65536;
        return q[PROB_W:0];
    endfunction

    function automatic rom_t build_tail_rom();
        rom_t r;
        for (int i = 0; i < CDF_DEPTH; i++) r[i] = tail_entry(i);
        return r;
    endfunction

endpackage

[src/ccpf_queue.sv]
// front part: two entry sample queue between the input stream and the engine
// depends on ccpf_pkg
module ccpf_queue
    import ccpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic signed [SAMPLE_W-1:0] push_data,
    output logic                       full,
    output logic                       item_valid,
    output logic signed [SAMPLE_W-1:0] item_data,
    input  logic                       pop
);

    logic signed [SAMPLE_W-1:0] slot_reg [2];
    logic                       wr_reg;
    logic                       rd_reg;
    logic [1:0]                 cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item_data  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[src/ccpf_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on ccpf_pkg
module ccpf_div
    import ccpf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    localparam logic [5:0] DIV_W6 = 6'(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DIV_W-1:0] quot_reg;
    logic [DSR_W:0]   trial;
    logic             ge;
    logic [DSR_W:0]   rem_step;

    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign rem_step = ge ? (trial - {1'b0, dsr_reg}) : trial;

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            dvd_reg  <= req.dividend << (DIV_W6 - req.nbits);
            dsr_reg  <= req.divisor;
            rem_reg  <= req.rem0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step[DSR_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
            dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/ccpf_sqrt.sv]
// integer square root, one result bit per cycle
// depends on ccpf_pkg
module ccpf_sqrt
    import ccpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [DIV_W-1:0]  value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [DIV_W-1:0] v_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] bit_reg;
    logic [DIV_W-1:0] sum;
    logic             ge;

    assign sum  = r_reg + bit_reg;
    assign ge   = (v_reg >= sum);
    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(DIV_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            v_reg   <= ge ? (v_reg - sum) : v_reg;
            r_reg   <= ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[src/ccpf_engine.sv]
// back part: warm-up statistics, cusum tail probability and bayes fusion sequencer
// depends on ccpf_pkg, ccpf_div and ccpf_sqrt
module ccpf_engine
    import ccpf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       item_valid,
    input  logic signed [SAMPLE_W-1:0] item_sample,
    output logic                       item_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output result_t                    out_res
);

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_NQ      = 20'h00002,
        ST_S2      = 20'h00004,
        ST_MEAN_GO = 20'h00008,
        ST_MEAN_W  = 20'h00010,
        ST_DEVD_GO = 20'h00020,
        ST_DEVD_W  = 20'h00040,
        ST_DEVS_W  = 20'h00080,
        ST_SQ1     = 20'h00100,
        ST_SQ2     = 20'h00200,
        ST_S_GO    = 20'h00400,
        ST_S_W     = 20'h00800,
        ST_IDX_W   = 20'h01000,
        ST_DECIDE  = 20'h02000,
        ST_FUSE    = 20'h04000,
        ST_BMUL1   = 20'h08000,
        ST_BMUL2   = 20'h10000,
        ST_BCHK    = 20'h20000,
        ST_BAY_W   = 20'h40000,
        ST_DONE    = 20'h80000
    } state_t;

    typedef enum logic [3:0] {
        MODE_FIRST  = 4'b0001,
        MODE_TRACK  = 4'b0010,
        MODE_REFILL = 4'b0100,
        MODE_HALT   = 4'b1000
    } mode_t;

    localparam rom_t TAIL_ROM = build_tail_rom();
    localparam logic signed [25:0] DSUM_MAX = 26'sd8388607;
    localparam logic [16:0] PROB_ONE = 17'h10000;

    state_t             state_reg, state_next;
    mode_t              mode_reg;
    logic [TIME_W-1:0]  tc_reg;
    logic [3:0]         bc_reg;
    logic [5:0]         wc_reg;
    logic signed [23:0] wsum_reg;
    logic [37:0]        wsq_reg;
    logic signed [23:0] mean_reg;
    logic [23:0]        dev_reg;
    logic signed [23:0] dsum_reg;
    logic [53:0]        prod_a_reg;
    logic [45:0]        prod_b_reg;
    logic [16:0]        p_reg;
    logic [15:0]        cur_reg;
    logic               cur_valid_reg;
    logic               change_reg;
    logic [15:0]        fused_reg;
    logic               fv_reg;
    logic [16:0]        past_reg;
    logic [16:0]        past_mem [MAX_TIMES];
    logic               out_valid_reg;
    result_t            res_reg;

    logic [5:0]         w_eff;
    logic [6:0]         t_eff;
    logic [4:0]         bc_eff;
    logic               out_free;
    logic               finish;
    logic               band_end;
    logic               last_band;
    logic signed [31:0] x_sq;
    logic signed [25:0] dsum_raw;
    logic signed [23:0] dsum_clamped;
    logic [22:0]        wsum_mag;
    logic signed [25:0] mean_num;
    logic [25:0]        mean_mag;
    logic [53:0]        dev_diff;
    logic [23:0]        dsum_mag;
    logic               sq_go;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    div_req_t           div_req;
    div_res_t           div_res;
    logic [23:0]        mean_q;

    assign w_eff  = (cfg.warmup_length < 6'd2) ? 6'd2 : cfg.warmup_length;
    assign t_eff  = (cfg.times_per_band < 7'd4) ? 7'd4 :
                    (cfg.times_per_band > 7'(MAX_TIMES)) ? 7'(MAX_TIMES) : cfg.times_per_band;
    assign bc_eff = (cfg.band_count < 5'd1) ? 5'd1 :
                    (cfg.band_count > 5'd16) ? 5'd16 : cfg.band_count;

    assign out_free  = !out_valid_reg || out_ready;
    assign finish    = (state_reg == ST_DONE) && out_free;
    assign band_end  = ({1'b0, tc_reg} + 7'd1) >= t_eff;
    assign last_band = ({1'b0, bc_reg} + 5'd1) >= bc_eff;
    assign item_pop  = (state_reg == ST_IDLE) && item_valid;

    assign x_sq         = 32'(item_sample) * 32'(item_sample);
    assign dsum_raw     = 26'(dsum_reg) + 26'(item_sample) - 26'(mean_reg);
    assign dsum_clamped = (dsum_raw > DSUM_MAX) ? 24'(DSUM_MAX) :
                          (dsum_raw < -DSUM_MAX) ? 24'(-DSUM_MAX) : dsum_raw[23:0];
    assign wsum_mag     = wsum_reg[23] ? 23'(-wsum_reg) : wsum_reg[22:0];
    assign mean_num     = (26'(wsum_reg) <<< 1) + 26'(wc_reg);
    assign mean_mag     = mean_num[25] ? 26'(-mean_num) : mean_num;
    assign dev_diff     = (prod_a_reg >= 54'(prod_b_reg)) ? (prod_a_reg - 54'(prod_b_reg)) : '0;
    assign dsum_mag     = dsum_reg[23] ? 24'(-dsum_reg) : 24'(dsum_reg);
    assign mean_q       = div_res.quot[23:0] + {23'd0, (div_res.rem != '0)};

    assign sq_go = ((state_reg == ST_DEVD_W) && div_res.done) || (state_reg == ST_S_GO);

    always_comb
    begin
        div_req = '0;
        case (state_reg)
            ST_MEAN_GO:
            begin
                div_req.go       = 1'b1;
                div_req.dividend = DIV_W'(mean_mag);
                div_req.divisor  = DSR_W'({wc_reg, 1'b0});
                div_req.nbits    = 6'd26;
            end
            ST_DEVD_GO:
            begin
                div_req.go       = 1'b1;
                div_req.dividend = DIV_W'(dev_diff[43:0]) << 16;
                div_req.divisor  = DSR_W'(wc_reg) * DSR_W'(wc_reg - 6'd1);
                div_req.nbits    = 6'(DIV_W);
            end
            ST_S_W:
            begin
                div_req.go       = sq_done && (sq_root != '0);
                div_req.dividend = DIV_W'({dsum_mag, 13'd0});
                div_req.divisor  = DSR_W'(sq_root);
                div_req.nbits    = 6'd37;
            end
            ST_BCHK:
            begin
                div_req.go       = (prod_b_reg != '0) && (54'(prod_a_reg) < 54'(prod_b_reg));
                div_req.divisor  = prod_b_reg[DSR_W-1:0];
                div_req.rem0     = prod_a_reg[DSR_W-1:0];
                div_req.nbits    = 6'(PROB_W);
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    ccpf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    ccpf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (sq_go),
        .value ((state_reg == ST_DEVD_W) ? div_res.quot : DIV_W'(prod_a_reg)),
        .done  (sq_done),
        .root  (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (mode_reg)
                        MODE_FIRST:  state_next = (({1'b0, wc_reg} + 7'd1) >= {1'b0, w_eff})
                                                  ? ST_NQ : ST_FUSE;
                        MODE_REFILL: state_next = (wc_reg < w_eff) ? ST_FUSE : ST_NQ;
                        MODE_TRACK:  state_next = ST_SQ1;
                        default:     state_next = ST_FUSE;
                    endcase
                end
            end
            ST_NQ:      state_next = ST_S2;
            ST_S2:      state_next = ST_MEAN_GO;
            ST_MEAN_GO: state_next = ST_MEAN_W;
            ST_MEAN_W:  state_next = div_res.done ? ST_DEVD_GO : ST_MEAN_W;
            ST_DEVD_GO: state_next = ST_DEVD_W;
            ST_DEVD_W:  state_next = div_res.done ? ST_DEVS_W : ST_DEVD_W;
            ST_DEVS_W:  state_next = sq_done ? ST_FUSE : ST_DEVS_W;
            ST_SQ1:     state_next = ST_SQ2;
            ST_SQ2:     state_next = ST_S_GO;
            ST_S_GO:    state_next = ST_S_W;
            ST_S_W:
            begin
                if (sq_done)
                begin
                    state_next = (sq_root == '0) ? ST_DECIDE : ST_IDX_W;
                end
            end
            ST_IDX_W:   state_next = div_res.done ? ST_DECIDE : ST_IDX_W;
            ST_DECIDE:  state_next = ST_FUSE;
            ST_FUSE:
            begin
                if (bc_reg == '0 || !cur_valid_reg || !past_reg[PROB_W])
                    state_next = ST_DONE;
                else
                    state_next = ST_BMUL1;
            end
            ST_BMUL1:   state_next = ST_BMUL2;
            ST_BMUL2:   state_next = ST_BCHK;
            ST_BCHK:    state_next = div_req.go ? ST_BAY_W : ST_DONE;
            ST_BAY_W:   state_next = div_res.done ? ST_DONE : ST_BAY_W;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // past probability store and its registered read port
    always_ff @(posedge clk)
    begin
        past_reg <= past_mem[tc_reg];
        if (finish)
        begin
            past_mem[tc_reg] <= {fv_reg, fused_reg};
        end
    end

    // working products and per-item values
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg       <= '0;
                cur_valid_reg <= 1'b1;
                change_reg    <= 1'b0;
                p_reg         <= '0;
            end
            ST_NQ:    prod_a_reg <= 54'(wc_reg) * 54'(wsq_reg);
            ST_S2:    prod_b_reg <= wsum_mag * wsum_mag;
            ST_SQ1:   prod_a_reg <= 54'(dev_reg) * 54'(dev_reg);
            ST_SQ2:   prod_a_reg <= 54'(prod_a_reg[47:0]) * 54'(tc_reg);
            ST_S_W:
            begin
                if (sq_done && sq_root == '0)
                begin
                    cur_valid_reg <= (dsum_reg != '0);
                end
            end
            ST_IDX_W:
            begin
                if (div_res.done)
                begin
                    p_reg <= (div_res.quot[DIV_W-1:8] == '0) ? TAIL_ROM[div_res.quot[7:0]] : '0;
                end
            end
            ST_DECIDE:
            begin
                if (cur_valid_reg)
                begin
                    cur_reg    <= (p_reg == '0) ? 16'hFFFF : 16'(PROB_ONE - p_reg);
                    change_reg <= (p_reg < {1'b0, cfg.tail_threshold});
                end
            end
            ST_FUSE:
            begin
                fv_reg    <= 1'b1;
                fused_reg <= cur_reg;
                if (bc_reg == '0)
                begin
                    fv_reg <= cur_valid_reg;
                end
                else if (!cur_valid_reg)
                begin
                    fv_reg    <= past_reg[PROB_W];
                    fused_reg <= past_reg[PROB_W-1:0];
                end
            end
            ST_BMUL1: prod_a_reg <= 54'(cur_reg) * 54'(past_reg[PROB_W-1:0]);
            ST_BMUL2: prod_b_reg <= 46'(prod_a_reg[31:0]) +
                                    46'(PROB_ONE - {1'b0, cur_reg}) *
                                    46'(PROB_ONE - {1'b0, past_reg[PROB_W-1:0]});
            ST_BCHK:
            begin
                if (prod_b_reg == '0)
                    fused_reg <= past_reg[PROB_W-1:0];
                else
                    fused_reg <= 16'hFFFF;
            end
            ST_BAY_W:
            begin
                if (div_res.done)
                begin
                    fused_reg <= div_res.quot[PROB_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FIRST;
            tc_reg        <= '0;
            bc_reg        <= '0;
            wc_reg        <= '0;
            wsum_reg      <= '0;
            wsq_reg       <= '0;
            mean_reg      <= '0;
            dev_reg       <= '0;
            dsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ready && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (mode_reg == MODE_FIRST ||
                            (mode_reg == MODE_REFILL && wc_reg < w_eff))
                        begin
                            wsum_reg <= wsum_reg + 24'(item_sample);
                            wsq_reg  <= wsq_reg + 38'(unsigned'(x_sq));
                            wc_reg   <= wc_reg + 6'd1;
                        end
                        if (mode_reg == MODE_TRACK)
                        begin
                            dsum_reg <= dsum_clamped;
                        end
                    end
                end
                ST_MEAN_W:
                begin
                    if (div_res.done)
                    begin
                        mean_reg <= mean_num[25] ? -signed'(mean_q) : signed'(div_res.quot[23:0]);
                    end
                end
                ST_DEVS_W:
                begin
                    if (sq_done)
                    begin
                        dev_reg  <= sq_root[23:0];
                        dsum_reg <= '0;
                        mode_reg <= MODE_TRACK;
                    end
                end
                ST_DECIDE:
                begin
                    if (cur_valid_reg && p_reg < {1'b0, cfg.tail_threshold})
                    begin
                        if ((8'(tc_reg) + 8'd1 + 8'(w_eff)) >= 8'(t_eff))
                        begin
                            mode_reg <= MODE_HALT;
                        end
                        else
                        begin
                            mode_reg <= MODE_REFILL;
                            wc_reg   <= '0;
                            wsum_reg <= '0;
                            wsq_reg  <= '0;
                            dsum_reg <= '0;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (band_end)
                        begin
                            tc_reg   <= '0;
                            bc_reg   <= last_band ? 4'd0 : bc_reg + 4'd1;
                            mode_reg <= MODE_FIRST;
                            wc_reg   <= '0;
                            wsum_reg <= '0;
                            wsq_reg  <= '0;
                            dsum_reg <= '0;
                        end
                        else
                        begin
                            tc_reg <= tc_reg + 6'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_reg.time_position     <= tc_reg;
            res_reg.fused_probability <= fv_reg ? fused_reg : '0;
            res_reg.change_flag       <= change_reg;
            res_reg.final_band        <= last_band;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

[src/cusum_change_probability_fusion_core.sv]
// top level: configuration registers, sample queue and processing engine
// depends on ccpf_pkg, ccpf_queue and ccpf_engine
// throughput: one sample at a time, set by the shared one-bit-per-cycle divider and root unit
// reset: asynchronous active low, clears counters, window statistics and registers to defaults
module cusum_change_probability_fusion_core
    import ccpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // time_position, fused_probability, zero pad
    output logic        m_tuser,   // change_flag
    output logic        m_tlast
);

    cfg_t                       cfg_reg;
    logic                       q_full;
    logic                       item_valid;
    logic signed [SAMPLE_W-1:0] item_sample;
    logic                       item_pop;
    result_t                    res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warmup_length  <= 6'd8;
            cfg_reg.tail_threshold <= 16'd3277;
            cfg_reg.times_per_band <= 7'd64;
            cfg_reg.band_count     <= 5'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WARMUP:    cfg_reg.warmup_length  <= cfg_data[5:0];
                REG_THRESHOLD: cfg_reg.tail_threshold <= cfg_data;
                REG_TIMES:     cfg_reg.times_per_band <= cfg_data[6:0];
                REG_BANDS:     cfg_reg.band_count     <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    ccpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && !q_full),
        .push_data  (signed'(s_tdata)),
        .full       (q_full),
        .item_valid (item_valid),
        .item_data  (item_sample),
        .pop        (item_pop)
    );

    ccpf_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item_sample (item_sample),
        .item_pop    (item_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tdata = {2'b00, res.fused_probability, res.time_position};
    assign m_tuser = res.change_flag;
    assign m_tlast = res.final_band;

endmodule

[src/ccpf_checker.sv]
// port level checks on the result stream of the core, attached by bind
// depends on cusum_change_probability_fusion_core_assert.svh
`include "cusum_change_probability_fusion_core_assert.svh"

module ccpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `CCPF_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result request changed")
    `CCPF_ASSERT_RST(a_reset_quiet, !rst_n |-> !m_tvalid, "result request offered during reset")
    `CCPF_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[23:22] == 2'b00, "result padding bits not zero")

endmodule

bind cusum_change_probability_fusion_core ccpf_checker u_ccpf_checker (.*);
